// ===== src/ack_range_scoreboard_defines.svh =====
// assertion macros used by the checker file
`ifndef ACK_RANGE_SCOREBOARD_DEFINES_SVH
`define ACK_RANGE_SCOREBOARD_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define ARS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ARS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/abr_pkg.sv =====
package abr_pkg;

	localparam int OFFSET_W = 62;
	localparam int LENGTH_W = 16;
	localparam int BYTES_W  = 24;
	localparam int HELD_W   = 5;

	typedef struct packed {
		logic [OFFSET_W-1:0] ack_offset;
		logic [LENGTH_W-1:0] ack_length;
		logic [BYTES_W-1:0]  buffered_bytes;
	} ack_t;

	typedef struct packed {
		logic [BYTES_W-1:0]  released_bytes;
		logic [OFFSET_W-1:0] cumulative_offset;
		logic                table_overflow;
		logic [HELD_W-1:0]   ranges_held;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MRD,
		ST_MEV,
		ST_MEND,
		ST_ARD,
		ST_AEV,
		ST_ADLT,
		ST_ASUM,
		ST_PRD,
		ST_PEV,
		ST_PEND,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_MERGE,
		PH_AFTER
	} phase_t;

endpackage

// ===== src/abr_ram.sv =====
module abr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/ack_range_scoreboard.sv =====
// channel  | signals                 | role
// ack      | ack_valid, ack_stall    | acknowledged range in, one transfer per item
// res      | res_valid, res_stall    | release result out, one transfer per item
//
// an ack that changes nothing (zero length or wholly below the offset) goes straight to the result
// otherwise a merge walk and a purge walk over the stored ranges, the purge stopping
// early when nothing drops
// tables sit in two ping-pong banks; a walk reads one bank and writes the other
// reset clears state, bank select, offset, range count and result valid; ram contents need no clearing
// ack_stall is high from the accept until the result is loaded; a held result delays the load
module ack_range_scoreboard import abr_pkg::*; #(
	parameter int RANGE_SLOTS = 16,
	parameter int OFFSET_BITS = 62
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ack_valid,
	output logic ack_stall,
	input  ack_t ack,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int CW = $clog2(RANGE_SLOTS + 1);
	localparam int IW = $clog2(RANGE_SLOTS);
	localparam int EW = 2 * OFFSET_BITS;

	state_t state_q, state_d;
	phase_t phase_q;

	logic                   bank_q;
	logic [CW-1:0]          cnt_q;
	logic [OFFSET_BITS-1:0] acked_q;
	logic                   res_valid_q;
	res_t                   res_q;

	logic [CW-1:0]          i_q, n_q;
	logic [OFFSET_BITS-1:0] start_q, end_q, diff_q;
	logic [BYTES_W-1:0]     buf_q, released_q;
	logic                   merged_q, inserted_q, ovf_q, adv_q, dropping_q;

	logic [EW-1:0]          rd0, rd1, rd_data, wr_data;
	logic [OFFSET_BITS-1:0] rd_first, rd_last;
	logic                   wr_en;

	logic [OFFSET_BITS-1:0] start_in, end_in;
	logic [OFFSET_BITS:0]   sum_in;
	logic                   acc, live_in, step_last, full, n_room, out_free;

	assign acc       = ack_valid && !ack_stall;
	assign ack_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || !res_stall;

	assign start_in = OFFSET_BITS'(ack.ack_offset);
	assign sum_in   = {1'b0, start_in} + (OFFSET_BITS + 1)'(ack.ack_length);
	// saturate the end at the top of the offset space
	assign end_in   = sum_in[OFFSET_BITS] ? '1 : sum_in[OFFSET_BITS-1:0];
	assign live_in  = (ack.ack_length != '0) && (end_in > acked_q);

	assign rd_data   = bank_q ? rd1 : rd0;
	assign rd_first  = rd_data[EW-1:OFFSET_BITS];
	assign rd_last   = rd_data[OFFSET_BITS-1:0];
	assign step_last = ((i_q + CW'(1)) == cnt_q);
	assign full      = !merged_q && (cnt_q == CW'(RANGE_SLOTS));
	assign n_room    = (n_q < CW'(RANGE_SLOTS));

	abr_ram #(.WIDTH(EW), .DEPTH(RANGE_SLOTS)) u_bank0 (
		.clk   (clk),
		.we    (wr_en && bank_q),
		.waddr (n_q[IW-1:0]),
		.wdata (wr_data),
		.raddr (i_q[IW-1:0]),
		.rdata (rd0)
	);

	abr_ram #(.WIDTH(EW), .DEPTH(RANGE_SLOTS)) u_bank1 (
		.clk   (clk),
		.we    (wr_en && !bank_q),
		.waddr (n_q[IW-1:0]),
		.wdata (wr_data),
		.raddr (i_q[IW-1:0]),
		.rdata (rd1)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (!live_in) state_d = ST_DONE;
					else if (cnt_q == '0) state_d = ST_MEND;
					else state_d = ST_MRD;
				end
			end
			ST_MRD: state_d = ST_MEV;
			ST_MEV: begin
				unique case (phase_q)
					PH_BEFORE: begin
						if (rd_last < start_q) state_d = step_last ? ST_MEND : ST_MRD;
					end
					PH_MERGE: begin
						if (rd_first <= end_q) state_d = step_last ? ST_MEND : ST_MRD;
					end
					PH_AFTER: begin
						if (!inserted_q) begin
							if (full) state_d = ST_ARD;
						end else begin
							state_d = step_last ? ST_MEND : ST_MRD;
						end
					end
					default: state_d = ST_MEND;
				endcase
			end
			ST_MEND: state_d = ST_ARD;
			ST_ARD:  state_d = (cnt_q == '0) ? ST_DONE : ST_AEV;
			ST_AEV:  state_d = ST_ADLT;
			ST_ADLT: state_d = ST_ASUM;
			ST_ASUM: state_d = ST_PRD;
			ST_PRD:  state_d = ST_PEV;
			ST_PEV: begin
				if (dropping_q && !(rd_last <= acked_q) && (i_q == '0)) state_d = ST_DONE;
				else state_d = step_last ? ST_PEND : ST_PRD;
			end
			ST_PEND: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// table writes into the idle bank
	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_data;
		unique case (state_q)
			ST_MEV: begin
				unique case (phase_q)
					PH_BEFORE: wr_en = (rd_last < start_q);
					PH_MERGE:  wr_en = 1'b0;
					PH_AFTER: begin
						if (!inserted_q) begin
							wr_en   = !full;
							wr_data = {start_q, end_q};
						end else begin
							wr_en = n_room;
						end
					end
					default: wr_en = 1'b0;
				endcase
			end
			ST_MEND: begin
				wr_en   = !inserted_q && !full;
				wr_data = {start_q, end_q};
			end
			ST_PEV: wr_en = !(dropping_q && (rd_last <= acked_q)) && (i_q != '0 || !dropping_q);
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bank_q      <= 1'b0;
			cnt_q       <= '0;
			acked_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_MEND: begin
					if (inserted_q || !full) begin
						bank_q <= !bank_q;
						cnt_q  <= inserted_q ? n_q : n_q + CW'(1);
					end
				end
				ST_ASUM: acked_q <= acked_q + OFFSET_BITS'(released_q);
				ST_PEND: begin
					bank_q <= !bank_q;
					cnt_q  <= n_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					start_q    <= (start_in < acked_q) ? acked_q : start_in;
					end_q      <= end_in;
					buf_q      <= ack.buffered_bytes;
					released_q <= '0;
					ovf_q      <= 1'b0;
					merged_q   <= 1'b0;
					inserted_q <= 1'b0;
					phase_q    <= PH_BEFORE;
					i_q        <= '0;
					n_q        <= '0;
				end
			end
			ST_MEV: begin
				unique case (phase_q)
					PH_BEFORE: begin
						if (rd_last < start_q) begin
							n_q <= n_q + CW'(1);
							i_q <= i_q + CW'(1);
						end else begin
							phase_q <= PH_MERGE;
						end
					end
					PH_MERGE: begin
						if (rd_first <= end_q) begin
							if (rd_first < start_q) start_q <= rd_first;
							if (rd_last > end_q) end_q <= rd_last;
							merged_q <= 1'b1;
							i_q      <= i_q + CW'(1);
						end else begin
							phase_q <= PH_AFTER;
						end
					end
					PH_AFTER: begin
						if (!inserted_q) begin
							if (full) begin
								// no room: table stays as it is
								ovf_q <= 1'b1;
								i_q   <= '0;
							end else begin
								n_q        <= n_q + CW'(1);
								inserted_q <= 1'b1;
							end
						end else begin
							if (n_room) n_q <= n_q + CW'(1);
							i_q <= i_q + CW'(1);
						end
					end
					default: ;
				endcase
			end
			ST_MEND: begin
				if (!inserted_q && full) ovf_q <= 1'b1;
				i_q <= '0;
			end
			ST_AEV: begin
				adv_q  <= (rd_first <= acked_q) && (rd_last > acked_q);
				diff_q <= rd_last - acked_q;
			end
			ST_ADLT: begin
				if (!adv_q) released_q <= '0;
				else if (diff_q > OFFSET_BITS'(buf_q)) released_q <= buf_q;
				else released_q <= diff_q[BYTES_W-1:0];
			end
			ST_ASUM: begin
				i_q        <= '0;
				n_q        <= '0;
				dropping_q <= 1'b1;
			end
			ST_PEV: begin
				if (dropping_q && (rd_last <= acked_q)) begin
					i_q <= i_q + CW'(1);
				end else if (!(dropping_q && i_q == '0)) begin
					// first kept range after a drop, or one after it: move down
					n_q        <= n_q + CW'(1);
					i_q        <= i_q + CW'(1);
					dropping_q <= 1'b0;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_q.released_bytes    <= released_q;
					res_q.cumulative_offset <= OFFSET_W'(acked_q);
					res_q.table_overflow    <= ovf_q;
					res_q.ranges_held       <= HELD_W'(cnt_q);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/abr_checker.sv =====
`include "ack_range_scoreboard_defines.svh"

module abr_checker import abr_pkg::*; #(
	parameter int RANGE_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic ack_valid,
	input logic ack_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// the input side is busy in the cycle after each accepted ack
	`ARS_ASSERT_NEXT(a_busy_after_accept, ack_valid && !ack_stall, ack_stall, "no busy after ack transfer")

	// a new result only appears after the block was working on an ack
	`ARS_ASSERT(a_result_after_work, $rose(res_valid) |-> $past(ack_stall), "result without work")

	// count never exceeds the table size
	`ARS_ASSERT(a_held_bound, !res_valid || RANGE_SLOTS > 31 || res.ranges_held <= 5'(RANGE_SLOTS), "ranges_held beyond table size")

	// a stalled result holds
	`ARS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

endmodule

bind ack_range_scoreboard abr_checker #(.RANGE_SLOTS(RANGE_SLOTS)) u_abr_checker (.*);

// ===== tb/sv/tb_ack_range_scoreboard.sv =====
module tb_ack_range_scoreboard;
	import abr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int unsigned LIMIT = 1000000;
	localparam int unsigned ITEMS = 850;
	localparam logic [63:0] OFF_MAX = {2'b00, {OFFSET_W{1'b1}}};

	logic clk;
	logic arst_n;
	logic ack_valid = 1'b0;
	logic ack_stall;
	ack_t ack = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	ack_range_scoreboard #(
		.RANGE_SLOTS(SLOTS),
		.OFFSET_BITS(OFFSET_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.ack_valid(ack_valid),
		.ack_stall(ack_stall),
		.ack(ack),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// predicted scoreboard state
	logic [OFFSET_W-1:0] cum_upto = '0;
	logic [OFFSET_W-1:0] span_lo[SLOTS];
	logic [OFFSET_W-1:0] span_hi[SLOTS];
	int span_cnt = 0;

	ack_t ack_backlog[$];
	res_t release_due[$];
	int unsigned cycles = 0;
	int unsigned made = 0;
	int err_cnt = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit calm;

	function automatic res_t apply_ack(ack_t a);
		logic [63:0] lo, hi, dlt;
		logic [OFFSET_W-1:0] nlo[SLOTS+1];
		logic [OFFSET_W-1:0] nhi[SLOTS+1];
		int n, i, drop;
		bit merged, ovf;
		res_t r;
		lo = {2'b00, a.ack_offset};
		hi = lo + {48'd0, a.ack_length};
		dlt = '0;
		ovf = 1'b0;
		merged = 1'b0;
		n = 0;
		i = 0;
		if (a.ack_length != 0) begin
			if (hi > OFF_MAX)
				hi = OFF_MAX;
			if (hi > {2'b00, cum_upto}) begin
				if (lo < {2'b00, cum_upto})
					lo = {2'b00, cum_upto};
				// ranges strictly below, not touching
				while (i < span_cnt && {2'b00, span_hi[i]} < lo) begin
					nlo[n] = span_lo[i];
					nhi[n] = span_hi[i];
					n++;
					i++;
				end
				// overlapping or touching ranges fold into the new one
				while (i < span_cnt && {2'b00, span_lo[i]} <= hi) begin
					if ({2'b00, span_lo[i]} < lo)
						lo = {2'b00, span_lo[i]};
					if ({2'b00, span_hi[i]} > hi)
						hi = {2'b00, span_hi[i]};
					merged = 1'b1;
					i++;
				end
				if (!merged && span_cnt >= SLOTS) begin
					ovf = 1'b1;
				end else begin
					nlo[n] = lo[OFFSET_W-1:0];
					nhi[n] = hi[OFFSET_W-1:0];
					n++;
					while (i < span_cnt && n < SLOTS) begin
						nlo[n] = span_lo[i];
						nhi[n] = span_hi[i];
						n++;
						i++;
					end
					for (int k = 0; k < n; k++) begin
						span_lo[k] = nlo[k];
						span_hi[k] = nhi[k];
					end
					span_cnt = n;
				end
				// advance over a covering first range, capped by buffered bytes
				if (span_cnt > 0 && span_lo[0] <= cum_upto && span_hi[0] > cum_upto) begin
					dlt = {2'b00, span_hi[0]} - {2'b00, cum_upto};
					if (dlt > {40'd0, a.buffered_bytes})
						dlt = {40'd0, a.buffered_bytes};
					cum_upto = cum_upto + dlt[OFFSET_W-1:0];
				end
				drop = 0;
				while (drop < span_cnt && span_hi[drop] <= cum_upto)
					drop++;
				if (drop > 0) begin
					for (int k = drop; k < span_cnt; k++) begin
						span_lo[k-drop] = span_lo[k];
						span_hi[k-drop] = span_hi[k];
					end
					span_cnt = span_cnt - drop;
				end
			end
		end
		r.released_bytes = dlt[BYTES_W-1:0];
		r.cumulative_offset = cum_upto;
		r.table_overflow = ovf;
		r.ranges_held = span_cnt[HELD_W-1:0];
		return r;
	endfunction

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 4);
		else if (r < 97)
			return $urandom_range(5, 20);
		return $urandom_range(30, 80);
	endfunction

	function automatic int pick_fill();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		else if (r < 30)
			return $urandom_range(1, 300);
		else if (r < 40)
			return 24'hFFFFFF;
		return $urandom_range(0, 24'hFFFFFF);
	endfunction

	function automatic logic [63:0] rand_offset();
		return {$urandom, $urandom} & OFF_MAX;
	endfunction

	task automatic push_ack(logic [63:0] off, int len, int fill);
		ack_t a;
		a.ack_offset = off[OFFSET_W-1:0];
		a.ack_length = len[LENGTH_W-1:0];
		a.buffered_bytes = fill[BYTES_W-1:0];
		ack_backlog.push_back(a);
		if (a.ack_length != 0)
			made++;
	endtask

	// sampled at the falling edge, away from the driver's updates
	task automatic wait_drained();
		while (ack_backlog.size() != 0 || ack_valid)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		calm = ((cycles / 3000) % 5) == 0;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (ack_valid && !ack_stall)
				release_due.push_back(apply_ack(ack));
			if (!ack_valid || !ack_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					ack_valid <= 1'b0;
				end else if (ack_backlog.size() != 0) begin
					ack <= ack_backlog.pop_front();
					ack_valid <= 1'b1;
					gap_left = calm ? 0 : pick_pause();
				end else begin
					ack_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (release_due.size() == 0) begin
					if (err_cnt < 10)
						$display("unexpected result transfer: %p", res);
					err_cnt++;
				end else begin
					e = release_due.pop_front();
					if (res.released_bytes !== e.released_bytes ||
							res.cumulative_offset !== e.cumulative_offset ||
							res.table_overflow !== e.table_overflow ||
							res.ranges_held !== e.ranges_held) begin
						if (err_cnt < 10)
							$display("mismatch exp/got: released %0d/%0d offset %0h/%0h ovf %0b/%0b held %0d/%0d",
								e.released_bytes, res.released_bytes,
								e.cumulative_offset, res.cumulative_offset,
								e.table_overflow, res.table_overflow,
								e.ranges_held, res.ranges_held);
						err_cnt++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				stall_left = calm ? 0 : pick_pause();
			end
		end
	end

	initial begin
		logic [63:0] cur, base, off, lim;
		int mode, cnt, len, stride, top_gap, tmp, j;
		int order[20];

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero length, release cap, below offset, table full, top of space
		push_ack(64'd0, 0, 0);
		push_ack(64'd0, 100, 0);
		push_ack(64'd0, 100, 50);
		push_ack(64'd10, 20, 24'hFFFFFF);
		push_ack(64'd100, 16'hFFFF, 24'hFFFFFF);
		for (int k = 0; k < SLOTS + 1; k++)
			push_ack(64'd70000 + 64'(k * 20), 10, 24'hFFFFFF);
		push_ack(64'd65635, 16'hFFFF, 24'hFFFFFF);
		push_ack(OFF_MAX, 16'hFFFF, 5);
		push_ack(OFF_MAX - 5, 5, 0);
		wait_drained();

		while (made < ITEMS) begin
			mode = $urandom_range(0, 99);
			cur = {2'b00, cum_upto};
			if (mode < 30) begin
				// mostly in order from the acked offset, some overlap below
				cnt = $urandom_range(1, 6);
				for (int k = 0; k < cnt; k++) begin
					off = cur;
					tmp = $urandom_range(0, 500);
					if (off >= 64'(tmp))
						off = off - 64'(tmp);
					if ($urandom_range(0, 3) == 0)
						off = off + 64'($urandom_range(1, 300));
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535)
						: $urandom_range(1, 4000);
					push_ack(off, len, pick_fill());
					cur = off + 64'(len);
				end
			end else if (mode < 55) begin
				// disjoint ranges above the offset in shuffled order
				base = cur + 64'($urandom_range(1, 2000));
				cnt = $urandom_range(3, 19);
				len = $urandom_range(1, 200);
				stride = len + $urandom_range(1, 400);
				for (int k = 0; k < cnt; k++)
					order[k] = k;
				for (int k = cnt - 1; k > 0; k--) begin
					j = $urandom_range(0, k);
					tmp = order[k];
					order[k] = order[j];
					order[j] = tmp;
				end
				for (int k = 0; k < cnt; k++)
					push_ack(base + 64'(order[k] * stride), len, pick_fill());
			end else if (mode < 75) begin
				cnt = $urandom_range(1, 8);
				for (int k = 0; k < cnt; k++) begin
					off = cur + 64'($urandom_range(0, 30000));
					tmp = $urandom_range(0, 3000);
					if (off >= 64'(tmp))
						off = off - 64'(tmp);
					push_ack(off, $urandom_range(1, 3000), pick_fill());
				end
			end else if (mode < 85) begin
				// one wide ack from the offset closes holes
				push_ack(cur, 16'hFFFF, pick_fill());
			end else begin
				cnt = $urandom_range(1, 4);
				for (int k = 0; k < cnt; k++) begin
					case ($urandom_range(0, 3))
						0: push_ack(rand_offset(), 0, $urandom_range(0, 24'hFFFFFF));
						1: begin
							// wholly below the acked offset
							lim = (cur > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : cur;
							if (lim > 1) begin
								len = $urandom_range(1, (lim > 65535) ? 65535 : int'(lim));
								off = 64'($urandom_range(0, int'(lim) - len));
								push_ack(off, len, pick_fill());
							end else begin
								push_ack(rand_offset(), 0, pick_fill());
							end
						end
						2: begin
							// top of the offset space, end saturates and merges
							top_gap = $urandom_range(0, 65535);
							len = $urandom_range((top_gap == 0) ? 1 : top_gap, 65535);
							push_ack(OFF_MAX - 64'(top_gap), len, pick_fill());
						end
						default: push_ack(rand_offset(), $urandom_range(1, 65535) * 0,
							pick_fill());
					endcase
				end
			end
			wait_drained();
		end

		while (release_due.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
